>>> design/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared widths, register indexes, reset table and control structs of the
// binary code modulation LED scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

    localparam int CHANNELS  = 16;
    localparam int LEVEL_W   = 8;
    localparam int PLANE_W   = 3;
    localparam int TICK_W    = 15;
    localparam int FRAME_W   = 8;
    localparam int PATTERN_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [PLANE_W-1:0]   LAST_PLANE          = PLANE_W'(7);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICKS      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_STEP = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] BASE_TICKS_RESET      = 8'h01;
    localparam logic [CFG_W-1:0] FRAMES_PER_STEP_RESET = 8'h08;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic               frame_end;
        logic               move;
    } t_tick_ctl;

    function automatic logic [LEVEL_W-1:0] level_init(input int idx);
        logic [LEVEL_W-1:0] v;
        case (idx)
            0:       v = 8'h04;
            1:       v = 8'h10;
            2:       v = 8'hFF;
            3:       v = 8'h10;
            4:       v = 8'h04;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/bcm_timebase.sv
// ----------------------------------------------------------------------------
// bcm_timebase
// Configuration registers and plane, tick and frame counters; flags frame
// ends and scanner moves.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_timebase import bcm_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg_wr   i_cfg,
    input  wire logic      i_step,
    output t_tick_ctl      o_ctl
);

    logic [CFG_W-1:0]   r_base_ticks;
    logic [CFG_W-1:0]   r_frames_per_step;
    logic [PLANE_W-1:0] r_plane, n_plane;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [FRAME_W-1:0] r_frame, n_frame;

    logic [TICK_W:0]    length;
    logic [TICK_W:0]    elapsed;
    logic [FRAME_W:0]   frame_next;
    logic               plane_done;
    logic               frame_done;
    logic               wrap;

    always_comb begin
        length     = {{(TICK_W + 1 - CFG_W){1'b0}}, r_base_ticks} << r_plane;
        elapsed    = {1'b0, r_tick} + (TICK_W + 1)'(1);
        frame_next = {1'b0, r_frame} + (FRAME_W + 1)'(1);
        plane_done = elapsed >= length;
        frame_done = plane_done && (r_plane == LAST_PLANE);
        wrap       = frame_next >= {1'b0, r_frames_per_step};

        n_plane = r_plane;
        n_tick  = r_tick;
        n_frame = r_frame;
        if (i_step) begin
            if (plane_done) begin
                n_tick  = '0;
                n_plane = r_plane + PLANE_W'(1);
                if (frame_done) begin
                    n_frame = wrap ? '0 : frame_next[FRAME_W-1:0];
                end
            end else begin
                n_tick = elapsed[TICK_W-1:0];
            end
        end

        o_ctl.plane     = r_plane;
        o_ctl.frame_end = i_step && frame_done;
        o_ctl.move      = i_step && frame_done && wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ticks      <= BASE_TICKS_RESET;
            r_frames_per_step <= FRAMES_PER_STEP_RESET;
            r_plane           <= '0;
            r_tick            <= '0;
            r_frame           <= '0;
        end else begin
            r_plane <= n_plane;
            r_tick  <= n_tick;
            r_frame <= n_frame;
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    CFG_BASE_TICKS:      r_base_ticks      <= i_cfg.data;
                    CFG_FRAMES_PER_STEP: r_frames_per_step <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> design/bcm_level_bank.sv
// ----------------------------------------------------------------------------
// bcm_level_bank
// Brightness levels with scanner shift and direction; selects the current
// bit plane of every shown channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_level_bank import bcm_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_tick_ctl       i_ctl,
    output logic [PATTERN_W-1:0] o_pattern
);

    localparam int SHOWN = (CHANNELS < PATTERN_W) ? CHANNELS : PATTERN_W;

    logic [LEVEL_W-1:0] r_levels [CHANNELS];
    logic [LEVEL_W-1:0] n_levels [CHANNELS];
    logic               r_down, n_down;

    always_comb begin
        if (r_levels[0] != '0) begin
            n_down = 1'b0;
        end else if (r_levels[CHANNELS-1] != '0) begin
            n_down = 1'b1;
        end else begin
            n_down = r_down;
        end

        for (int k = 0; k < CHANNELS; k++) begin
            if (n_down) begin
                n_levels[k] = (k == CHANNELS - 1) ? '0 : r_levels[(k + 1) % CHANNELS];
            end else begin
                n_levels[k] = (k == 0) ? '0 : r_levels[(k + CHANNELS - 1) % CHANNELS];
            end
        end

        o_pattern = '0;
        for (int k = 0; k < SHOWN; k++) begin
            o_pattern[k] = r_levels[k][i_ctl.plane];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_levels[k] <= level_init(k);
            end
        end else if (i_ctl.move) begin
            r_down <= n_down;
            for (int k = 0; k < CHANNELS; k++) begin
                r_levels[k] <= n_levels[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/bcm_led_scanner_core.sv
// ----------------------------------------------------------------------------
// bcm_led_scanner_core
// Binary code modulation LED scanner: one time-base tick per non-blank input
// transfer, one displayed bit-plane pattern per output transfer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  cfg       in         i_cfg_we                 i_cfg_index, i_cfg_data
//  tick      in         i_in_valid / o_in_ready  i_blank
//  result    out        o_out_valid / i_out_ready o_led_pattern, o_plane_index,
//                                                o_frame_end
//
//  One input transfer per cycle sustained while the output is not stalled; a
//  tick lands in the input register at its transfer and its result moves to
//  the result register once the output side can take it.
//  Synchronous active-low reset restores levels and counters; no clear pass.
//  An output stall holds the result register; input keeps flowing until the
//  input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_led_scanner_core import bcm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_blank,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [PATTERN_W-1:0]      o_led_pattern,
    output logic [PLANE_W-1:0]        o_plane_index,
    output logic                      o_frame_end
);

    logic                 r_in_valid;
    logic                 r_in_blank;
    logic                 r_out_valid;
    logic [PATTERN_W-1:0] r_pattern;
    logic [PLANE_W-1:0]   r_plane;
    logic                 r_frame_end;

    logic                 advance;
    logic                 step;
    logic [PATTERN_W-1:0] pattern;
    t_cfg_wr              cfg;
    t_tick_ctl            ctl;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign step       = advance && !r_in_blank;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        cfg.we    = i_cfg_we;
        cfg.index = i_cfg_index;
        cfg.data  = i_cfg_data;
    end

    bcm_timebase u_timebase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .o_ctl   (ctl)
    );

    bcm_level_bank u_level_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .o_pattern (pattern)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_blank <= i_blank;
        end
        if (advance) begin
            r_pattern   <= r_in_blank ? '0 : pattern;
            r_plane     <= ctl.plane;
            r_frame_end <= ctl.frame_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_pattern = r_pattern;
    assign o_plane_index = r_plane;
    assign o_frame_end   = r_frame_end;

    a_frame_end_last_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_plane_index == LAST_PLANE)
        else $error("frame end reported outside the last plane");

    a_move_on_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.move |-> ctl.frame_end && step)
        else $error("scanner move without a frame end");

    a_plane_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.frame_end |=> ctl.plane == '0)
        else $error("plane did not return to zero after a frame");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input held off without a full pipeline");

endmodule

`default_nettype wire
